// ===== rtl/mlp_batch_gradient_trainer_unit_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the MLP batch gradient trainer
// Clocked on clk, disabled while rst is high.
// ---------------------------------------------------------------------------
`ifndef MLP_BATCH_GRADIENT_TRAINER_UNIT_ASSERT_SVH
`define MLP_BATCH_GRADIENT_TRAINER_UNIT_ASSERT_SVH

// The expression must never be true.
`define MBGT_ASSERT_NEVER(name, expr) \
  name: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("assertion failed: forbidden condition");

// When the trigger holds, the expression holds in the next cycle.
`define MBGT_ASSERT_NEXT(name, trig, expr) \
  name: assert property (@(posedge clk) disable iff (rst) (trig) |=> (expr)) \
    else $error("assertion failed: condition after trigger");

`endif

// ===== rtl/mbgt_pkg.sv =====
// ---------------------------------------------------------------------------
// MLP batch gradient trainer package
// Types, constants, microcode program and saturation helper.
// ---------------------------------------------------------------------------
package mbgt_pkg;

  localparam int NUM_FEATURES = 3;
  localparam int NODES        = 7;
  localparam int WEIGHTS      = 10;
  localparam int ACC_W        = 50;
  localparam int DIV_W        = 48;
  localparam int LR_W         = 17;
  localparam int RC_W         = 11;

  localparam logic [1:0] KIND_PRED   = 2'd0;
  localparam logic [1:0] KIND_WEIGHT = 2'd1;
  localparam logic [1:0] KIND_BIAS   = 2'd2;

  localparam logic REG_STEP_SIZE = 1'b0;
  localparam logic REG_ROW_COUNT = 1'b1;

  localparam logic signed [31:0] INIT_W [WEIGHTS] = '{
    32'sd13107, 32'sd19661, 32'sd26214, 32'sd32768, 32'sd39322,
    32'sd45875, 32'sd72090, 32'sd78643, 32'sd131072, 32'sd137626
  };
  localparam logic signed [31:0] INIT_B [NODES] = '{
    32'sd209715, 32'sd216269, 32'sd229376, 32'sd249037,
    32'sd255590, 32'sd262144, 32'sd111411
  };

  typedef enum logic [3:0] {
    OP_LDB, OP_MAC, OP_STN, OP_ERR, OP_LOSS, OP_EMITP, OP_BGR, OP_WGR,
    OP_CLR, OP_BAK, OP_STD, OP_END, OP_UPW, OP_UPB, OP_FIN
  } op_t;

  typedef enum logic [2:0] {
    S_IDLE, S_EXEC, S_MUL, S_DIV, S_OUT
  } state_t;

  typedef struct packed {
    op_t        op;
    logic [2:0] n;
    logic [2:0] p;
    logic       pf;
    logic [3:0] wi;
  } instr_t;

  function automatic instr_t ins(op_t op, int n, int p, bit pf, int wi);
    instr_t r;
    r.op = op;
    r.n  = 3'(n);
    r.p  = 3'(p);
    r.pf = pf;
    r.wi = 4'(wi);
    return r;
  endfunction

  localparam int PROG_LEN = 82;
  localparam int PC_W     = $clog2(PROG_LEN);

  localparam instr_t PROG [PROG_LEN] = '{
    ins(OP_LDB, 0, 0, 0, 0), ins(OP_MAC, 0, 0, 1, 0), ins(OP_MAC, 0, 1, 1, 1),
    ins(OP_MAC, 0, 2, 1, 2), ins(OP_STN, 0, 0, 0, 0),
    ins(OP_LDB, 1, 0, 0, 0), ins(OP_MAC, 1, 0, 0, 3), ins(OP_STN, 1, 0, 0, 0),
    ins(OP_LDB, 2, 0, 0, 0), ins(OP_MAC, 2, 0, 0, 4), ins(OP_STN, 2, 0, 0, 0),
    ins(OP_LDB, 3, 0, 0, 0), ins(OP_MAC, 3, 1, 0, 5), ins(OP_MAC, 3, 2, 0, 6),
    ins(OP_STN, 3, 0, 0, 0),
    ins(OP_LDB, 4, 0, 0, 0), ins(OP_MAC, 4, 3, 0, 7), ins(OP_STN, 4, 0, 0, 0),
    ins(OP_LDB, 5, 0, 0, 0), ins(OP_MAC, 5, 4, 0, 8), ins(OP_STN, 5, 0, 0, 0),
    ins(OP_LDB, 6, 0, 0, 0), ins(OP_MAC, 6, 5, 0, 9), ins(OP_STN, 6, 0, 0, 0),
    ins(OP_ERR, 0, 0, 0, 0), ins(OP_LOSS, 0, 0, 0, 0), ins(OP_EMITP, 0, 0, 0, 0),
    ins(OP_BGR, 6, 0, 0, 0), ins(OP_WGR, 6, 5, 0, 9), ins(OP_CLR, 0, 0, 0, 0),
    ins(OP_BAK, 6, 0, 0, 9), ins(OP_STD, 0, 5, 0, 0),
    ins(OP_BGR, 5, 0, 0, 0), ins(OP_WGR, 5, 4, 0, 8), ins(OP_CLR, 0, 0, 0, 0),
    ins(OP_BAK, 5, 0, 0, 8), ins(OP_STD, 0, 4, 0, 0),
    ins(OP_BGR, 4, 0, 0, 0), ins(OP_WGR, 4, 3, 0, 7), ins(OP_CLR, 0, 0, 0, 0),
    ins(OP_BAK, 4, 0, 0, 7), ins(OP_STD, 0, 3, 0, 0),
    ins(OP_BGR, 3, 0, 0, 0), ins(OP_WGR, 3, 1, 0, 5), ins(OP_WGR, 3, 2, 0, 6),
    ins(OP_CLR, 0, 0, 0, 0), ins(OP_BAK, 3, 0, 0, 5), ins(OP_STD, 0, 1, 0, 0),
    ins(OP_CLR, 0, 0, 0, 0), ins(OP_BAK, 3, 0, 0, 6), ins(OP_STD, 0, 2, 0, 0),
    ins(OP_BGR, 1, 0, 0, 0), ins(OP_WGR, 1, 0, 0, 3),
    ins(OP_BGR, 2, 0, 0, 0), ins(OP_WGR, 2, 0, 0, 4),
    ins(OP_CLR, 0, 0, 0, 0), ins(OP_BAK, 1, 0, 0, 3), ins(OP_BAK, 2, 0, 0, 4),
    ins(OP_STD, 0, 0, 0, 0),
    ins(OP_BGR, 0, 0, 0, 0), ins(OP_WGR, 0, 0, 1, 0), ins(OP_WGR, 0, 1, 1, 1),
    ins(OP_WGR, 0, 2, 1, 2),
    ins(OP_END, 0, 0, 0, 0),
    ins(OP_UPW, 0, 0, 0, 0), ins(OP_UPW, 0, 0, 0, 1), ins(OP_UPW, 0, 0, 0, 2),
    ins(OP_UPW, 0, 0, 0, 3), ins(OP_UPW, 0, 0, 0, 4), ins(OP_UPW, 0, 0, 0, 5),
    ins(OP_UPW, 0, 0, 0, 6), ins(OP_UPW, 0, 0, 0, 7), ins(OP_UPW, 0, 0, 0, 8),
    ins(OP_UPW, 0, 0, 0, 9),
    ins(OP_UPB, 0, 0, 0, 0), ins(OP_UPB, 1, 0, 0, 0), ins(OP_UPB, 2, 0, 0, 0),
    ins(OP_UPB, 3, 0, 0, 0), ins(OP_UPB, 4, 0, 0, 0), ins(OP_UPB, 5, 0, 0, 0),
    ins(OP_UPB, 6, 0, 0, 0),
    ins(OP_FIN, 0, 0, 0, 0)
  };

  function automatic logic signed [31:0] sat32(logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) begin
      r = 32'sh7FFFFFFF;
    end else if (v < -64'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/mbgt_in_if.sv =====
// ---------------------------------------------------------------------------
// Training row channel
// Valid/ready channel carrying one training row per beat.
// ---------------------------------------------------------------------------
interface mbgt_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] feature_0;
  logic signed [31:0] feature_1;
  logic signed [31:0] feature_2;
  logic signed [31:0] target;
  logic               end_of_batch;

  modport source (output valid, feature_0, feature_1, feature_2, target, end_of_batch,
                  input ready);
  modport sink (input valid, feature_0, feature_1, feature_2, target, end_of_batch,
                output ready);
endinterface

// ===== rtl/mbgt_out_if.sv =====
// ---------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying one prediction or updated parameter per beat.
// ---------------------------------------------------------------------------
interface mbgt_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic [3:0]         slot;
  logic signed [31:0] value;
  logic [30:0]        loss;
  logic               last;

  modport source (output valid, kind, slot, value, loss, last, input ready);
  modport sink (input valid, kind, slot, value, loss, last, output ready);
endinterface

// ===== rtl/mlp_batch_gradient_trainer_unit.sv =====
// ---------------------------------------------------------------------------
// MLP batch gradient trainer
// Forward pass, backpropagation and batch update of a small ReLU network
// in Q16.16, run by a microcoded sequencer over one multiplier and one
// divider.
// ---------------------------------------------------------------------------
// Channel   Direction  Beat
// row       in         three features, target and end-of-batch mark
// result    out        prediction with loss, or one updated parameter
// wr_*      in         register write, no handshake
//
// A row keeps the block busy through 17 gradient divisions, each on
// the shared divider, and the next row is accepted only once the block
// is back in idle. The last row of a batch adds the update of every
// weight and bias, plus any output stall.
// Reset is synchronous and needs no clearing pass. A stalled result beat
// holds the sequencer.
// ---------------------------------------------------------------------------
`include "mlp_batch_gradient_trainer_unit_assert.svh"

module mlp_batch_gradient_trainer_unit (
  input  logic                        clk,
  input  logic                        rst,
  mbgt_in_if.sink                     row,
  mbgt_out_if.source                  result,
  input  logic                        wr_en,
  input  logic                        wr_index,
  input  logic [mbgt_pkg::LR_W-1:0]   wr_data
);

  localparam int NODES   = mbgt_pkg::NODES;
  localparam int WEIGHTS = mbgt_pkg::WEIGHTS;
  localparam int ACC_W   = mbgt_pkg::ACC_W;
  localparam int DIV_W   = mbgt_pkg::DIV_W;
  localparam int PC_W    = mbgt_pkg::PC_W;

  mbgt_pkg::state_t state, state_next;
  logic [PC_W-1:0]  pc;
  mbgt_pkg::instr_t cur;

  logic signed [31:0] feat [mbgt_pkg::NUM_FEATURES];
  logic signed [31:0] target;
  logic               eob;

  logic signed [31:0] weight_store    [WEIGHTS];
  logic signed [31:0] bias_store      [NODES];
  logic signed [31:0] weight_grad_sum [WEIGHTS];
  logic signed [31:0] bias_grad_sum   [NODES];
  logic signed [31:0] node_scratch    [NODES];
  logic signed [31:0] delta           [NODES];

  logic signed [ACC_W-1:0]       acc;
  logic [30:0]                   loss;
  logic signed [32:0]            err;
  logic [mbgt_pkg::LR_W-1:0]     step_size;
  logic [mbgt_pkg::RC_W-1:0]     row_count;
  logic [mbgt_pkg::RC_W-1:0]     rc_eff;

  logic [1:0]         res_kind;
  logic [3:0]         res_slot;
  logic signed [31:0] res_value;
  logic [30:0]        res_loss;
  logic               res_last;

  logic signed [32:0]       mul_a, mul_b;
  logic signed [65:0]       prod;
  logic signed [DIV_W-1:0]  prod_q;
  logic                     div_start, div_done;
  logic signed [DIV_W-1:0]  div_dividend, div_q;

  logic signed [31:0] x_val;
  logic signed [31:0] xs;
  logic signed [32:0] err_now;
  logic signed [31:0] upd_new;
  logic               out_free;
  logic               accept;
  logic               big_err;
  logic [47:0]        sq;

  assign cur      = mbgt_pkg::PROG[pc];
  assign prod_q   = prod[63:16];
  assign out_free = !result.valid || result.ready;
  assign accept   = row.valid && row.ready;
  assign row.ready = state == mbgt_pkg::S_IDLE;
  assign rc_eff   = (row_count == '0) ? mbgt_pkg::RC_W'(1) : row_count;
  assign xs       = node_scratch[cur.p];
  assign x_val    = cur.pf ? feat[cur.p[1:0]] : ((xs > 0) ? xs : 32'sd0);
  assign err_now  = 33'(node_scratch[NODES-1]) - 33'(target);
  assign big_err  = (err >= 33'sd16777216) || (err <= -33'sd16777216);
  assign sq       = prod[63:16];

  mbgt_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  mbgt_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (rc_eff),
    .done     (div_done),
    .quotient (div_q)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      mbgt_pkg::S_IDLE: begin
        if (accept) state_next = mbgt_pkg::S_EXEC;
      end
      mbgt_pkg::S_EXEC: begin
        case (cur.op) inside
          mbgt_pkg::OP_MAC, mbgt_pkg::OP_WGR, mbgt_pkg::OP_BAK, mbgt_pkg::OP_LOSS,
          mbgt_pkg::OP_UPW, mbgt_pkg::OP_UPB: state_next = mbgt_pkg::S_MUL;
          mbgt_pkg::OP_BGR:   state_next = mbgt_pkg::S_DIV;
          mbgt_pkg::OP_EMITP: state_next = mbgt_pkg::S_OUT;
          mbgt_pkg::OP_END:   state_next = eob ? mbgt_pkg::S_EXEC : mbgt_pkg::S_IDLE;
          mbgt_pkg::OP_FIN:   state_next = mbgt_pkg::S_IDLE;
          default:            state_next = mbgt_pkg::S_EXEC;
        endcase
      end
      mbgt_pkg::S_MUL: begin
        case (cur.op) inside
          mbgt_pkg::OP_WGR:                   state_next = mbgt_pkg::S_DIV;
          mbgt_pkg::OP_UPW, mbgt_pkg::OP_UPB: state_next = mbgt_pkg::S_OUT;
          default:                            state_next = mbgt_pkg::S_EXEC;
        endcase
      end
      mbgt_pkg::S_DIV: begin
        if (div_done) state_next = mbgt_pkg::S_EXEC;
      end
      mbgt_pkg::S_OUT: begin
        if (out_free) state_next = mbgt_pkg::S_EXEC;
      end
      default: state_next = mbgt_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cur.op)
      mbgt_pkg::OP_MAC: begin
        mul_a = 33'(x_val);
        mul_b = 33'(weight_store[cur.wi]);
      end
      mbgt_pkg::OP_WGR: begin
        mul_a = 33'(delta[cur.n]);
        mul_b = 33'(x_val);
      end
      mbgt_pkg::OP_BAK: begin
        mul_a = 33'(delta[cur.n]);
        mul_b = 33'(weight_store[cur.wi]);
      end
      mbgt_pkg::OP_LOSS: begin
        mul_a = err;
        mul_b = err;
      end
      mbgt_pkg::OP_UPW: begin
        mul_a = 33'(weight_grad_sum[cur.wi]);
        mul_b = $signed({16'd0, step_size});
      end
      mbgt_pkg::OP_UPB: begin
        mul_a = 33'(bias_grad_sum[cur.n]);
        mul_b = $signed({16'd0, step_size});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    div_start = ((state == mbgt_pkg::S_EXEC) && (cur.op == mbgt_pkg::OP_BGR)) ||
                ((state == mbgt_pkg::S_MUL) && (cur.op == mbgt_pkg::OP_WGR));
    div_dividend = (cur.op == mbgt_pkg::OP_BGR) ? DIV_W'(delta[cur.n]) : prod_q;
    if (cur.op == mbgt_pkg::OP_UPW) begin
      upd_new = mbgt_pkg::sat32(64'(weight_store[cur.wi]) - 64'(prod_q));
    end else begin
      upd_new = mbgt_pkg::sat32(64'(bias_store[cur.n]) - 64'(prod_q));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mbgt_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc              <= '0;
      result.valid    <= 1'b0;
      step_size       <= mbgt_pkg::LR_W'(6554);
      row_count       <= mbgt_pkg::RC_W'(5);
      weight_store    <= mbgt_pkg::INIT_W;
      bias_store      <= mbgt_pkg::INIT_B;
      weight_grad_sum <= '{default: '0};
      bias_grad_sum   <= '{default: '0};
    end else begin
      if (wr_en) begin
        unique case (wr_index)
          mbgt_pkg::REG_STEP_SIZE: step_size <= wr_data;
          mbgt_pkg::REG_ROW_COUNT: row_count <= wr_data[mbgt_pkg::RC_W-1:0];
          default: ;
        endcase
      end
      if (result.valid && result.ready && state != mbgt_pkg::S_OUT) begin
        result.valid <= 1'b0;
      end
      if (accept) begin
        feat[0] <= row.feature_0;
        feat[1] <= row.feature_1;
        feat[2] <= row.feature_2;
        target  <= row.target;
        eob     <= row.end_of_batch;
        pc      <= '0;
      end
      case (state)
        mbgt_pkg::S_EXEC: begin
          case (cur.op)
            mbgt_pkg::OP_LDB: begin
              acc <= ACC_W'(bias_store[cur.n]);
              pc  <= pc + 1'b1;
            end
            mbgt_pkg::OP_STN: begin
              node_scratch[cur.n] <= mbgt_pkg::sat32(64'(acc));
              pc <= pc + 1'b1;
            end
            mbgt_pkg::OP_CLR: begin
              acc <= '0;
              pc  <= pc + 1'b1;
            end
            mbgt_pkg::OP_STD: begin
              delta[cur.p] <= (xs > 0) ? mbgt_pkg::sat32(64'(acc)) : 32'sd0;
              pc <= pc + 1'b1;
            end
            mbgt_pkg::OP_ERR: begin
              err <= err_now;
              delta[NODES-1] <= mbgt_pkg::sat32(64'(err_now) + 64'(err_now));
              pc <= pc + 1'b1;
            end
            mbgt_pkg::OP_EMITP: begin
              res_kind  <= mbgt_pkg::KIND_PRED;
              res_slot  <= '0;
              res_value <= node_scratch[NODES-1];
              res_loss  <= loss;
              res_last  <= !eob;
            end
            mbgt_pkg::OP_END: begin
              pc <= pc + 1'b1;
            end
            default: ;
          endcase
        end
        mbgt_pkg::S_MUL: begin
          case (cur.op)
            mbgt_pkg::OP_MAC, mbgt_pkg::OP_BAK: begin
              acc <= acc + ACC_W'(prod_q);
              pc  <= pc + 1'b1;
            end
            mbgt_pkg::OP_LOSS: begin
              loss <= (big_err || (sq > 48'h7FFFFFFF)) ? 31'h7FFFFFFF : sq[30:0];
              pc   <= pc + 1'b1;
            end
            mbgt_pkg::OP_UPW: begin
              weight_store[cur.wi]    <= upd_new;
              weight_grad_sum[cur.wi] <= '0;
              res_kind  <= mbgt_pkg::KIND_WEIGHT;
              res_slot  <= cur.wi;
              res_value <= upd_new;
              res_loss  <= '0;
              res_last  <= 1'b0;
            end
            mbgt_pkg::OP_UPB: begin
              bias_store[cur.n]    <= upd_new;
              bias_grad_sum[cur.n] <= '0;
              res_kind  <= mbgt_pkg::KIND_BIAS;
              res_slot  <= 4'(cur.n);
              res_value <= upd_new;
              res_loss  <= '0;
              res_last  <= cur.n == 3'(NODES - 1);
            end
            default: ;
          endcase
        end
        mbgt_pkg::S_DIV: begin
          if (div_done) begin
            if (cur.op == mbgt_pkg::OP_BGR) begin
              bias_grad_sum[cur.n] <=
                mbgt_pkg::sat32(64'(bias_grad_sum[cur.n]) + 64'(div_q));
            end else begin
              weight_grad_sum[cur.wi] <=
                mbgt_pkg::sat32(64'(weight_grad_sum[cur.wi]) + 64'(div_q));
            end
            pc <= pc + 1'b1;
          end
        end
        mbgt_pkg::S_OUT: begin
          if (out_free) begin
            result.valid <= 1'b1;
            result.kind  <= res_kind;
            result.slot  <= res_slot;
            result.value <= res_value;
            result.loss  <= res_loss;
            result.last  <= res_last;
            pc <= pc + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  `MBGT_ASSERT_NEXT(a_accept_starts, row.valid && row.ready, state == mbgt_pkg::S_EXEC && pc == '0)
  `MBGT_ASSERT_NEVER(a_pc_range, int'(pc) >= mbgt_pkg::PROG_LEN)
  `MBGT_ASSERT_NEXT(a_stall_holds_pc, state == mbgt_pkg::S_OUT && result.valid && !result.ready, $stable(pc))
  `MBGT_ASSERT_NEVER(a_div_in_state, div_done && state != mbgt_pkg::S_DIV)

endmodule

// ===== rtl/mbgt_mul.sv =====
// ---------------------------------------------------------------------------
// Shared multiplier
// Signed 33 by 33 multiply with a registered 66-bit product.
// ---------------------------------------------------------------------------
module mbgt_mul (
  input  logic               clk,
  input  logic signed [32:0] a,
  input  logic signed [32:0] b,
  output logic signed [65:0] prod
);

  always_ff @(posedge clk) begin
    prod <= a * b;
  end

endmodule

// ===== rtl/mbgt_div.sv =====
// ---------------------------------------------------------------------------
// Shared divider
// Restoring division of a signed value by an unsigned row count, one
// quotient bit per cycle, truncated toward zero.
// ---------------------------------------------------------------------------
module mbgt_div (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  input  logic signed [mbgt_pkg::DIV_W-1:0]    dividend,
  input  logic        [mbgt_pkg::RC_W-1:0]     divisor,
  output logic                                 done,
  output logic signed [mbgt_pkg::DIV_W-1:0]    quotient
);

  localparam int DW = mbgt_pkg::DIV_W;
  localparam int RW = mbgt_pkg::RC_W;
  localparam int CW = $clog2(DW);

  logic [DW-1:0] quo;
  logic [RW-1:0] rem;
  logic [CW-1:0] cnt;
  logic          busy;
  logic          neg;
  logic [RW:0]   rem_sh;
  logic          ge;
  logic [RW:0]   rem_sub;

  assign rem_sh  = {rem, quo[DW-1]};
  assign ge      = rem_sh >= {1'b0, divisor};
  assign rem_sub = rem_sh - {1'b0, divisor};
  assign quotient = neg ? -$signed(quo) : $signed(quo);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        rem  <= '0;
        neg  <= dividend[DW-1];
        quo  <= dividend[DW-1] ? DW'(-dividend) : DW'(dividend);
      end else if (busy) begin
        quo <= {quo[DW-2:0], ge};
        rem <= ge ? rem_sub[RW-1:0] : rem_sh[RW-1:0];
        cnt <= cnt + 1'b1;
        if (cnt == CW'(DW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule
